// ===== rtl/dhke_pkg.sv =====
// shared constants for the diffie-hellman key exchange core
// no dependencies

package dhke_pkg;

  localparam int KEY_WIDTH_DEF = 32;

  // count of keys seen in the current set, saturating at two
  typedef logic [1:0] keys_cnt_t;

  localparam keys_cnt_t KEYS_NONE = 2'd0;
  localparam keys_cnt_t KEYS_ONE  = 2'd1;
  localparam keys_cnt_t KEYS_TWO  = 2'd2;

endpackage

// ===== rtl/diffie_hellman_key_exchange_core.sv =====
// diffie-hellman key exchange core: modular exponentiation on a shared
// add-and-reduce unit under a small sequencer; uses dhke_pkg
//
// usage:
//   in_*  stream carries one private key per item, in_tlast marks the final
//         key of a set. each item yields its public key generator^key mod
//         modulus (out_tuser 0). on a final item of a set with at least two
//         keys, a second item follows with the shared key (out_tuser 1),
//         second public key raised to the first private key. out_tlast
//         marks the last result of each input item.
//   cfg_* apb port holds modulus (offset 0) and generator (offset 4, or 8
//         when KEY_WIDTH exceeds 32). write only while the core is idle.
// operation:
//   one modular multiply does one double and one add step per multiplier
//   bit on the single add-and-reduce unit. one exponentiation is one
//   reduction multiply plus up to 2*KEY_WIDTH-1 multiplies; a final item
//   with a shared key costs two exponentiations. in_tready is high only
//   while idle. results sit in an output register: a stalled receiver
//   stalls the core only when the next result is ready to be loaded.
// reset: modulus 2, generator 0, key set empty, no result pending.

module diffie_hellman_key_exchange_core #(
  parameter int KEY_WIDTH = dhke_pkg::KEY_WIDTH_DEF,
  localparam int TDW    = ((KEY_WIDTH + 7) / 8) * 8,
  localparam int DW     = (KEY_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_W = (KEY_WIDTH > 32) ? 4 : 3
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [TDW-1:0]    in_tdata,   // private_key
  input  logic              in_tlast,   // last_key
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [TDW-1:0]    out_tdata,  // value
  output logic              out_tuser,  // kind
  output logic              out_tlast,  // last_result
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DW-1:0]     cfg_pwdata,
  output logic [DW-1:0]     cfg_prdata,
  output logic              cfg_pready
);

  import dhke_pkg::*;

  localparam int KW = KEY_WIDTH;
  localparam int CW = $clog2(KW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POW,
    S_BIT,
    S_SQR,
    S_MUL,
    S_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  state_t          ret_r, ret_nxt;
  logic [KW-1:0]   modulus_r, modulus_nxt;
  logic [KW-1:0]   generator_r, generator_nxt;
  logic [KW-1:0]   first_private_r, first_private_nxt;
  logic [KW-1:0]   second_public_r, second_public_nxt;
  keys_cnt_t       keys_seen_r, keys_seen_nxt;
  logic [KW-1:0]   priv_r, priv_nxt;
  logic            last_r, last_nxt;
  logic            pow_sel_r, pow_sel_nxt;
  logic            shared_r, shared_nxt;
  logic [KW-1:0]   base_r, base_nxt;
  logic [KW-1:0]   exp_r, exp_nxt;
  logic [KW-1:0]   acc_r, acc_nxt;
  logic [KW-1:0]   sq_r, sq_nxt;
  logic [KW-1:0]   res_r, res_nxt;
  logic            res_kind_r, res_kind_nxt;
  logic            res_last_r, res_last_nxt;
  logic [KW-1:0]   ma_r, ma_nxt;
  logic [KW-1:0]   mb_r, mb_nxt;
  logic [KW-1:0]   mr_r, mr_nxt;
  logic            phase_r, phase_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            dest_sq_r, dest_sq_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [KW-1:0]   out_value_r, out_value_nxt;
  logic            out_kind_r, out_kind_nxt;
  logic            out_last_r, out_last_nxt;

  logic            cfg_wr;
  logic [KW-1:0]   u_x, u_y, u_res;
  logic [KW:0]     u_sum;
  logic            done;
  logic [KW-1:0]   done_val;
  keys_cnt_t       ks_inc;
  logic            will_share;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = cfg_paddr[ADDR_W-1] ? DW'(generator_r) : DW'(modulus_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDW'(out_value_r);
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // shared add-and-reduce unit: (x + y) mod m for x, y below m
  assign u_x   = mr_r;
  assign u_y   = phase_r ? (mb_r[KW-1] ? ma_r : '0) : mr_r;
  assign u_sum = {1'b0, u_x} + {1'b0, u_y};
  assign u_res = (u_sum >= {1'b0, modulus_r}) ? KW'(u_sum - {1'b0, modulus_r})
                                                : u_sum[KW-1:0];

  always_comb begin
    state_nxt         = state_r;
    ret_nxt           = ret_r;
    modulus_nxt       = modulus_r;
    generator_nxt     = generator_r;
    first_private_nxt = first_private_r;
    second_public_nxt = second_public_r;
    keys_seen_nxt     = keys_seen_r;
    priv_nxt          = priv_r;
    last_nxt          = last_r;
    pow_sel_nxt       = pow_sel_r;
    shared_nxt        = shared_r;
    base_nxt          = base_r;
    exp_nxt           = exp_r;
    acc_nxt           = acc_r;
    sq_nxt            = sq_r;
    res_nxt           = res_r;
    res_kind_nxt      = res_kind_r;
    res_last_nxt      = res_last_r;
    ma_nxt            = ma_r;
    mb_nxt            = mb_r;
    mr_nxt            = mr_r;
    phase_nxt         = phase_r;
    cnt_nxt           = cnt_r;
    dest_sq_nxt       = dest_sq_r;
    out_valid_nxt     = out_valid_r & ~out_tready;
    out_value_nxt     = out_value_r;
    out_kind_nxt      = out_kind_r;
    out_last_nxt      = out_last_r;
    done              = 1'b0;
    done_val          = '0;
    ks_inc            = (keys_seen_r == KEYS_TWO) ? KEYS_TWO : keys_seen_r + KEYS_ONE;
    will_share       = last_r & (ks_inc == KEYS_TWO);

    if (cfg_wr) begin
      if (cfg_paddr[ADDR_W-1]) begin
        generator_nxt = cfg_pwdata[KW-1:0];
      end else begin
        modulus_nxt = cfg_pwdata[KW-1:0];
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          priv_nxt    = in_tdata[KW-1:0];
          exp_nxt     = in_tdata[KW-1:0];
          base_nxt    = generator_r;
          last_nxt    = in_tlast;
          pow_sel_nxt = 1'b0;
          state_nxt   = S_POW;
        end
      end
      S_POW: begin
        if (modulus_r < KW'(2)) begin
          done = 1'b1;
        end else if (exp_r == '0) begin
          done     = 1'b1;
          done_val = KW'(1);
        end else begin
          // reduce the base: horner over its bits with multiplicand 1
          acc_nxt     = KW'(1);
          ma_nxt      = KW'(1);
          mb_nxt      = base_r;
          mr_nxt      = '0;
          phase_nxt   = 1'b0;
          cnt_nxt     = CW'(KW - 1);
          dest_sq_nxt = 1'b1;
          ret_nxt     = S_BIT;
          state_nxt   = S_MUL;
        end
      end
      S_BIT: begin
        if (exp_r[0]) begin
          ma_nxt      = acc_r;
          mb_nxt      = sq_r;
          mr_nxt      = '0;
          phase_nxt   = 1'b0;
          cnt_nxt     = CW'(KW - 1);
          dest_sq_nxt = 1'b0;
          ret_nxt     = S_SQR;
          state_nxt   = S_MUL;
        end else begin
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        if (exp_r[KW-1:1] != '0) begin
          exp_nxt     = exp_r >> 1;
          ma_nxt      = sq_r;
          mb_nxt      = sq_r;
          mr_nxt      = '0;
          phase_nxt   = 1'b0;
          cnt_nxt     = CW'(KW - 1);
          dest_sq_nxt = 1'b1;
          ret_nxt     = S_BIT;
          state_nxt   = S_MUL;
        end else begin
          done     = 1'b1;
          done_val = acc_r;
        end
      end
      S_MUL: begin
        mr_nxt    = u_res;
        phase_nxt = ~phase_r;
        if (phase_r) begin
          mb_nxt  = mb_r << 1;
          cnt_nxt = cnt_r - CW'(1);
          if (cnt_r == '0) begin
            if (dest_sq_r) begin
              sq_nxt = u_res;
            end else begin
              acc_nxt = u_res;
            end
            state_nxt = ret_r;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          out_kind_nxt  = res_kind_r;
          out_last_nxt  = res_last_r;
          if (shared_r) begin
            shared_nxt  = 1'b0;
            pow_sel_nxt = 1'b1;
            base_nxt    = second_public_r;
            exp_nxt     = first_private_r;
            state_nxt   = S_POW;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (done) begin
      res_nxt   = done_val;
      state_nxt = S_EMIT;
      if (!pow_sel_r) begin
        if (keys_seen_r == KEYS_NONE) begin
          first_private_nxt = priv_r;
        end else if (keys_seen_r == KEYS_ONE) begin
          second_public_nxt = done_val;
        end
        keys_seen_nxt = last_r ? KEYS_NONE : ks_inc;
        shared_nxt    = will_share;
        res_kind_nxt  = 1'b0;
        res_last_nxt  = ~will_share;
      end else begin
        shared_nxt   = 1'b0;
        res_kind_nxt = 1'b1;
        res_last_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      ret_r           <= S_IDLE;
      modulus_r       <= KW'(2);
      generator_r     <= '0;
      first_private_r <= '0;
      second_public_r <= '0;
      keys_seen_r     <= KEYS_NONE;
      shared_r        <= 1'b0;
      pow_sel_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      ret_r           <= ret_nxt;
      modulus_r       <= modulus_nxt;
      generator_r     <= generator_nxt;
      first_private_r <= first_private_nxt;
      second_public_r <= second_public_nxt;
      keys_seen_r     <= keys_seen_nxt;
      shared_r        <= shared_nxt;
      pow_sel_r       <= pow_sel_nxt;
      out_valid_r     <= out_valid_nxt;
    end
    priv_r      <= priv_nxt;
    last_r      <= last_nxt;
    base_r      <= base_nxt;
    exp_r       <= exp_nxt;
    acc_r       <= acc_nxt;
    sq_r        <= sq_nxt;
    res_r       <= res_nxt;
    res_kind_r  <= res_kind_nxt;
    res_last_r  <= res_last_nxt;
    ma_r        <= ma_nxt;
    mb_r        <= mb_nxt;
    mr_r        <= mr_nxt;
    phase_r     <= phase_nxt;
    cnt_r       <= cnt_nxt;
    dest_sq_r   <= dest_sq_nxt;
    out_value_r <= out_value_nxt;
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule
